/* design/sch_pkg.sv */
`default_nettype none

package sch_pkg;

    localparam int RADIUS_BITS = 16;
    localparam int R2_BITS     = 2 * RADIUS_BITS;
    localparam int NUM_STAGES  = 7;
    localparam int GEOM_STAGES = 3;
    localparam int TEST_STAGES = NUM_STAGES - GEOM_STAGES;
    localparam int MUL_STAGES  = 2;

endpackage

`default_nettype wire

/* design/segment_circle_hit_test.sv */
// segment / circle hit test, streaming
// input channel s_*: one beat carries a segment (start, end), a circle
// center and a radius; coordinates are two's complement of COORD_BITS bits
// result channel m_*: one beat per input beat, in order, with m_hit set when
// the nearest point of the segment lies within the radius, and
// m_inside_span set when the center projects strictly between the end points
// throughput: one beat per cycle while m_ready is high; the seven register
// stages (differences, products, sums, partial products, product sums, wide
// add, compare) can each hold a different beat
// stall: each stage holds while the stage after it is full and held, so
// s_ready stays high as long as any stage has room; nothing is dropped or
// repeated
// reset: aresetn low at a rising edge of aclk clears all stage valid bits; the
// pipeline comes out of reset empty and ready
`default_nettype none

module segment_circle_hit_test #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [COORD_BITS-1:0]         s_start_x,
    input  wire logic signed [COORD_BITS-1:0]         s_start_y,
    input  wire logic signed [COORD_BITS-1:0]         s_end_x,
    input  wire logic signed [COORD_BITS-1:0]         s_end_y,
    input  wire logic signed [COORD_BITS-1:0]         s_center_x,
    input  wire logic signed [COORD_BITS-1:0]         s_center_y,
    input  wire logic [sch_pkg::RADIUS_BITS-1:0]      s_radius,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_hit,
    output logic                                      m_inside_span
);
    import sch_pkg::*;

    localparam int W2 = 2 * COORD_BITS + 2;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    logic signed [W2-1:0] dot;
    logic [W2-1:0]        len2;
    logic [W2-1:0]        dist_start;
    logic [W2-1:0]        dist_end;
    logic [R2_BITS-1:0]   r2;

    sch_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .aclk       (aclk),
        .en         (en[GEOM_STAGES-1:0]),
        .start_x    (s_start_x),
        .start_y    (s_start_y),
        .end_x      (s_end_x),
        .end_y      (s_end_y),
        .center_x   (s_center_x),
        .center_y   (s_center_y),
        .radius     (s_radius),
        .dot        (dot),
        .len2       (len2),
        .dist_start (dist_start),
        .dist_end   (dist_end),
        .r2         (r2)
    );

    sch_decide #(.COORD_BITS(COORD_BITS)) u_decide (
        .aclk        (aclk),
        .en          (en[NUM_STAGES-1:GEOM_STAGES]),
        .dot         (dot),
        .len2        (len2),
        .dist_start  (dist_start),
        .dist_end    (dist_end),
        .r2          (r2),
        .hit         (m_hit),
        .inside_span (m_inside_span)
    );

    assign s_ready = en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

/* design/sch_mul.sv */
`default_nettype none

module sch_mul #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  wire logic                 aclk,
    input  wire logic [sch_pkg::MUL_STAGES-1:0] en,
    input  wire logic [AW-1:0]        a,
    input  wire logic [BW-1:0]        b,
    output logic      [AW+BW-1:0]     p
);
    import sch_pkg::*;

    localparam int PW = AW + BW;
    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    // partial products
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ll_reg <= (AL+BL)'(a[AL-1:0])  * (AL+BL)'(b[BL-1:0]);
            lh_reg <= (AL+BH)'(a[AL-1:0])  * (AL+BH)'(b[BW-1:BL]);
            hl_reg <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
            hh_reg <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
        end
    end

    always_comb begin
        p_next = (PW'(hh_reg) << (AL + BL)) + (PW'(hl_reg) << AL)
               + (PW'(lh_reg) << BL) + PW'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* design/sch_geom.sv */
`default_nettype none

module sch_geom #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic [sch_pkg::GEOM_STAGES-1:0]       en,
    input  wire logic signed [COORD_BITS-1:0]          start_x,
    input  wire logic signed [COORD_BITS-1:0]          start_y,
    input  wire logic signed [COORD_BITS-1:0]          end_x,
    input  wire logic signed [COORD_BITS-1:0]          end_y,
    input  wire logic signed [COORD_BITS-1:0]          center_x,
    input  wire logic signed [COORD_BITS-1:0]          center_y,
    input  wire logic [sch_pkg::RADIUS_BITS-1:0]       radius,
    output logic signed [2*COORD_BITS+1:0]             dot,
    output logic [2*COORD_BITS+1:0]                    len2,
    output logic [2*COORD_BITS+1:0]                    dist_start,
    output logic [2*COORD_BITS+1:0]                    dist_end,
    output logic [sch_pkg::R2_BITS-1:0]                r2
);
    import sch_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int W2 = 2 * C + 2;

    // stage 1: differences
    logic signed [C:0] dx_reg, dy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic [RADIUS_BITS-1:0] r_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dx_reg <= {end_x[C-1], end_x} - {start_x[C-1], start_x};
            dy_reg <= {end_y[C-1], end_y} - {start_y[C-1], start_y};
            vx_reg <= {center_x[C-1], center_x} - {start_x[C-1], start_x};
            vy_reg <= {center_y[C-1], center_y} - {start_y[C-1], start_y};
            wx_reg <= {center_x[C-1], center_x} - {end_x[C-1], end_x};
            wy_reg <= {center_y[C-1], center_y} - {end_y[C-1], end_y};
            r_reg  <= radius;
        end
    end

    // stage 2: products
    logic signed [W2-1:0] pdv_x_reg, pdv_y_reg, pdd_x_reg, pdd_y_reg;
    logic signed [W2-1:0] pvv_x_reg, pvv_y_reg, pww_x_reg, pww_y_reg;
    logic [R2_BITS-1:0]   r2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pdv_x_reg <= W2'(dx_reg * vx_reg);
            pdv_y_reg <= W2'(dy_reg * vy_reg);
            pdd_x_reg <= W2'(dx_reg * dx_reg);
            pdd_y_reg <= W2'(dy_reg * dy_reg);
            pvv_x_reg <= W2'(vx_reg * vx_reg);
            pvv_y_reg <= W2'(vy_reg * vy_reg);
            pww_x_reg <= W2'(wx_reg * wx_reg);
            pww_y_reg <= W2'(wy_reg * wy_reg);
            r2_reg    <= R2_BITS'(r_reg) * R2_BITS'(r_reg);
        end
    end

    // stage 3: dot products and squared lengths
    logic signed [W2-1:0] dot_reg;
    logic [W2-1:0]        len2_reg, ds_reg, de_reg;
    logic [R2_BITS-1:0]   r2_s3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            dot_reg   <= pdv_x_reg + pdv_y_reg;
            len2_reg  <= $unsigned(pdd_x_reg) + $unsigned(pdd_y_reg);
            ds_reg    <= $unsigned(pvv_x_reg) + $unsigned(pvv_y_reg);
            de_reg    <= $unsigned(pww_x_reg) + $unsigned(pww_y_reg);
            r2_s3_reg <= r2_reg;
        end
    end

    assign dot        = dot_reg;
    assign len2       = len2_reg;
    assign dist_start = ds_reg;
    assign dist_end   = de_reg;
    assign r2         = r2_s3_reg;

endmodule

`default_nettype wire

/* design/sch_decide.sv */
`default_nettype none

module sch_decide #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic [sch_pkg::TEST_STAGES-1:0]   en,
    input  wire logic signed [2*COORD_BITS+1:0]    dot,
    input  wire logic [2*COORD_BITS+1:0]           len2,
    input  wire logic [2*COORD_BITS+1:0]           dist_start,
    input  wire logic [2*COORD_BITS+1:0]           dist_end,
    input  wire logic [sch_pkg::R2_BITS-1:0]       r2,
    output logic                                   hit,
    output logic                                   inside_span
);
    import sch_pkg::*;

    localparam int W2 = 2 * COORD_BITS + 2;
    localparam int AP = 2 * W2;
    localparam int BP = R2_BITS + W2;
    localparam int SW = ((AP > BP) ? AP : BP) + 1;
    localparam int CW = (W2 > R2_BITS) ? W2 : R2_BITS;

    logic          inside_next;
    logic          endhit_next;
    logic [W2-1:0] dmin;
    logic [W2-1:0] dot_u;

    always_comb begin
        dot_u       = $unsigned(dot);
        inside_next = !dot[W2-1] && (dot != '0) && (dot_u < len2);
        dmin        = (dist_start < dist_end) ? dist_start : dist_end;
        endhit_next = CW'(dmin) <= CW'(r2);
    end

    // stage 4 and 5: flags ride along with the multipliers
    logic inside4_reg, endhit4_reg, inside5_reg, endhit5_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            inside4_reg <= inside_next;
            endhit4_reg <= endhit_next;
        end
        if (en[1]) begin
            inside5_reg <= inside4_reg;
            endhit5_reg <= endhit4_reg;
        end
    end

    logic [AP-1:0] vl_prod;
    logic [BP-1:0] rl_prod;
    logic [AP-1:0] tt_prod;

    sch_mul #(.AW(W2), .BW(W2)) u_mul_vl (
        .aclk (aclk),
        .en   (en[1:0]),
        .a    (dist_start),
        .b    (len2),
        .p    (vl_prod)
    );

    sch_mul #(.AW(R2_BITS), .BW(W2)) u_mul_rl (
        .aclk (aclk),
        .en   (en[1:0]),
        .a    (r2),
        .b    (len2),
        .p    (rl_prod)
    );

    sch_mul #(.AW(W2), .BW(W2)) u_mul_tt (
        .aclk (aclk),
        .en   (en[1:0]),
        .a    (dot_u),
        .b    (dot_u),
        .p    (tt_prod)
    );

    // stage 6: r^2*L + t^2
    logic [SW-1:0] rhs_reg;
    logic [AP-1:0] lhs_reg;
    logic          inside6_reg, endhit6_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            rhs_reg     <= SW'(rl_prod) + SW'(tt_prod);
            lhs_reg     <= vl_prod;
            inside6_reg <= inside5_reg;
            endhit6_reg <= endhit5_reg;
        end
    end

    // stage 7: final compare
    logic hit_reg, inside_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            hit_reg    <= inside6_reg ? (SW'(lhs_reg) <= rhs_reg) : endhit6_reg;
            inside_reg <= inside6_reg;
        end
    end

    assign hit         = hit_reg;
    assign inside_span = inside_reg;

endmodule

`default_nettype wire

/* design/sch_checker.sv */
`default_nettype none

module sch_checker #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    input  wire logic                                 s_ready,
    input  wire logic signed [COORD_BITS-1:0]         s_start_x,
    input  wire logic signed [COORD_BITS-1:0]         s_start_y,
    input  wire logic signed [COORD_BITS-1:0]         s_end_x,
    input  wire logic signed [COORD_BITS-1:0]         s_end_y,
    input  wire logic signed [COORD_BITS-1:0]         s_center_x,
    input  wire logic signed [COORD_BITS-1:0]         s_center_y,
    input  wire logic [sch_pkg::RADIUS_BITS-1:0]      s_radius,
    input  wire logic                                 m_valid,
    input  wire logic                                 m_ready,
    input  wire logic                                 m_hit,
    input  wire logic                                 m_inside_span
);
    import sch_pkg::*;

    // pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_inside_span))
        else $error("result beat changed while stalled");

    // a free output stage frees the whole pipeline
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input held off with free output");

    // with the input held off the output was full and stalled
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input held off without output stall");

endmodule

bind segment_circle_hit_test sch_checker #(.COORD_BITS(COORD_BITS)) u_sch_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;

    import sch_pkg::*;

    localparam int CB          = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_QUERIES = 600;

    typedef enum int {MODE_WIDE, MODE_CLUSTER, MODE_AXIS} shape_mode_t;

    typedef struct {
        logic signed [CB-1:0]          start_x;
        logic signed [CB-1:0]          start_y;
        logic signed [CB-1:0]          end_x;
        logic signed [CB-1:0]          end_y;
        logic signed [CB-1:0]          center_x;
        logic signed [CB-1:0]          center_y;
        logic [RADIUS_BITS-1:0]        radius;
        bit                            known;
        bit                            want_hit;
        bit                            want_inside;
    } query_t;

    typedef struct {
        int unsigned idx;
        bit          hit;
        bit          in_span;
    } verdict_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid    = 1'b0;
    logic                          s_ready;
    logic signed [CB-1:0]          s_start_x  = '0;
    logic signed [CB-1:0]          s_start_y  = '0;
    logic signed [CB-1:0]          s_end_x    = '0;
    logic signed [CB-1:0]          s_end_y    = '0;
    logic signed [CB-1:0]          s_center_x = '0;
    logic signed [CB-1:0]          s_center_y = '0;
    logic [RADIUS_BITS-1:0]        s_radius   = '0;
    logic                          m_valid;
    logic                          m_ready    = 1'b0;
    logic                          m_hit;
    logic                          m_inside_span;

    // expectation typed into the table, carried with the beat
    logic row_known       = 1'b0;
    logic row_want_hit    = 1'b0;
    logic row_want_inside = 1'b0;

    logic quiet = 1'b0;

    query_t      stimulus_rows[$];
    verdict_t    pending_verdicts[$];
    int unsigned errors       = 0;
    int unsigned queries_in   = 0;
    int unsigned verdicts_out = 0;
    int unsigned hits_seen    = 0;
    int unsigned spans_seen   = 0;
    int unsigned stuck_cycles = 0;

    segment_circle_hit_test #(
        .COORD_BITS(CB)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_radius     (s_radius),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_inside_span(m_inside_span)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // exact squared-distance test, returns {hit, inside_span}
    function automatic logic [1:0] segment_verdict(query_t q);
        longint       sx, sy, ex, ey, cx, cy, rad;
        longint       dx, dy, vx, vy, proj, span2, v2, de;
        logic [127:0] lhs, rhs;
        bit           in_span;
        bit           hit;
        sx = q.start_x;
        sy = q.start_y;
        ex = q.end_x;
        ey = q.end_y;
        cx = q.center_x;
        cy = q.center_y;
        rad = q.radius;
        dx = ex - sx;
        dy = ey - sy;
        vx = cx - sx;
        vy = cy - sy;
        proj  = dx * vx + dy * vy;
        span2 = dx * dx + dy * dy;
        v2    = vx * vx + vy * vy;
        in_span = (proj > 0) && (proj < span2);
        if (in_span) begin
            lhs = 128'(v2) * 128'(span2);
            rhs = 128'(rad * rad) * 128'(span2) + 128'(proj) * 128'(proj);
            hit = lhs <= rhs;
        end else begin
            de  = (cx - ex) * (cx - ex) + (cy - ey) * (cy - ey);
            hit = ((v2 < de) ? v2 : de) <= rad * rad;
        end
        return {hit, in_span};
    endfunction

    task automatic add_row(int sx, int sy, int ex, int ey, int cx, int cy, int rad,
                           bit known, bit hit, bit span);
        query_t q;
        q.start_x     = CB'(sx);
        q.start_y     = CB'(sy);
        q.end_x       = CB'(ex);
        q.end_y       = CB'(ey);
        q.center_x    = CB'(cx);
        q.center_y    = CB'(cy);
        q.radius      = RADIUS_BITS'(rad);
        q.known       = known;
        q.want_hit    = hit;
        q.want_inside = span;
        stimulus_rows.push_back(q);
    endtask

    task automatic report_mismatch(string what, int unsigned idx, logic got, logic want);
        $display("mismatch on %s, query %0d: got %b, want %b", what, idx, got, want);
        errors++;
    endtask

    task automatic send_query(query_t q);
        while (!quiet && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_start_x       <= q.start_x;
        s_start_y       <= q.start_y;
        s_end_x         <= q.end_x;
        s_end_y         <= q.end_y;
        s_center_x      <= q.center_x;
        s_center_y      <= q.center_y;
        s_radius        <= q.radius;
        row_known       <= q.known;
        row_want_hit    <= q.want_hit;
        row_want_inside <= q.want_inside;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    function automatic query_t random_query(shape_mode_t mode);
        query_t q;
        int     bx, by, seglen, off, h, rad;
        logic signed [CB-1:0] tmp;
        q.known       = 1'b0;
        q.want_hit    = 1'b0;
        q.want_inside = 1'b0;
        case (mode)
            MODE_WIDE: begin
                q.start_x  = CB'($urandom_range(65535));
                q.start_y  = CB'($urandom_range(65535));
                q.end_x    = CB'($urandom_range(65535));
                q.end_y    = CB'($urandom_range(65535));
                q.center_x = CB'($urandom_range(65535));
                q.center_y = CB'($urandom_range(65535));
                q.radius   = RADIUS_BITS'($urandom_range(65535));
            end
            MODE_CLUSTER: begin
                bx = int'($urandom_range(64000)) - 32000;
                by = int'($urandom_range(64000)) - 32000;
                q.start_x  = CB'(bx + int'($urandom_range(40)) - 20);
                q.start_y  = CB'(by + int'($urandom_range(40)) - 20);
                q.end_x    = CB'(bx + int'($urandom_range(40)) - 20);
                q.end_y    = CB'(by + int'($urandom_range(40)) - 20);
                q.center_x = CB'(bx + int'($urandom_range(40)) - 20);
                q.center_y = CB'(by + int'($urandom_range(40)) - 20);
                q.radius   = RADIUS_BITS'($urandom_range(25));
            end
            default: begin
                // axis-aligned segment, radius within one of the perpendicular distance
                bx     = int'($urandom_range(64000)) - 32000;
                by     = int'($urandom_range(64000)) - 32000;
                seglen = int'($urandom_range(1, 200));
                off    = int'($urandom_range(seglen + 40)) - 20;
                h      = int'($urandom_range(200)) - 100;
                rad    = ((h < 0) ? -h : h) + int'($urandom_range(2)) - 1;
                if (rad < 0) begin
                    rad = 0;
                end
                q.start_x  = CB'(bx);
                q.start_y  = CB'(by);
                q.end_x    = CB'(bx + seglen);
                q.end_y    = CB'(by);
                q.center_x = CB'(bx + off);
                q.center_y = CB'(by + h);
                q.radius   = RADIUS_BITS'(rad);
                if ($urandom_range(1)) begin
                    tmp = q.start_x;  q.start_x  = q.start_y;  q.start_y  = tmp;
                    tmp = q.end_x;    q.end_x    = q.end_y;    q.end_y    = tmp;
                    tmp = q.center_x; q.center_x = q.center_y; q.center_y = tmp;
                end
                if ($urandom_range(1)) begin
                    tmp = q.start_x; q.start_x = q.end_x; q.end_x = tmp;
                    tmp = q.start_y; q.start_y = q.end_y; q.end_y = tmp;
                end
            end
        endcase
        return q;
    endfunction

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 24);
    end

    always @(posedge aclk) begin : monitor
        verdict_t    exp_v;
        query_t      q;
        logic [1:0]  calc;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                verdicts_out++;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("unexpected beat", verdicts_out, m_hit, 1'bx);
                end else begin
                    exp_v = pending_verdicts.pop_front();
                    if (m_hit !== exp_v.hit) begin
                        report_mismatch("hit", exp_v.idx, m_hit, exp_v.hit);
                    end
                    if (m_inside_span !== exp_v.in_span) begin
                        report_mismatch("inside_span", exp_v.idx, m_inside_span,
                                        exp_v.in_span);
                    end
                end
                if (m_hit === 1'b1) begin
                    hits_seen++;
                end
                if (m_inside_span === 1'b1) begin
                    spans_seen++;
                end
            end
            if (s_valid && s_ready) begin
                q.start_x  = s_start_x;
                q.start_y  = s_start_y;
                q.end_x    = s_end_x;
                q.end_y    = s_end_y;
                q.center_x = s_center_x;
                q.center_y = s_center_y;
                q.radius   = s_radius;
                calc = segment_verdict(q);
                exp_v.idx     = queries_in;
                exp_v.hit     = row_known ? row_want_hit : calc[1];
                exp_v.in_span = row_known ? row_want_inside : calc[0];
                pending_verdicts.push_back(exp_v);
                queries_in++;
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("no progress for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        shape_mode_t mode;
        int unsigned pick;
        // zero-length segments
        add_row(0, 0, 0, 0, 0, 0, 0, 1, 1, 0);
        add_row(5, 5, 5, 5, 5, 8, 3, 1, 1, 0);
        add_row(5, 5, 5, 5, 5, 8, 2, 1, 0, 0);
        // interior projection, on the boundary and just outside
        add_row(0, 0, 10, 0, 5, 3, 3, 0, 0, 0);
        add_row(0, 0, 10, 0, 5, 3, 2, 0, 0, 0);
        // projection on the end points and beyond
        add_row(0, 0, 10, 0, 0, 5, 5, 1, 1, 0);
        add_row(0, 0, 10, 0, 10, 5, 4, 1, 0, 0);
        add_row(0, 0, 10, 0, 20, 0, 10, 1, 1, 0);
        add_row(0, 0, 10, 0, -5, 0, 4, 1, 0, 0);
        // zero radius on and off the segment
        add_row(0, 0, 10, 0, 3, 0, 0, 1, 1, 1);
        add_row(0, 0, 10, 0, 3, 1, 0, 1, 0, 1);
        // coordinate and radius extremes
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 65535, 1, 1, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, 0, 1, 1, 0);
        add_row(-32768, -32768, 32767, 32767, 32767, -32768, 65535, 0, 0, 0);
        add_row(32767, 32767, -32768, -32768, -32768, 32767, 0, 0, 0, 0);
        add_row(-32768, 0, 32767, 0, 0, 32767, 32767, 0, 0, 0);
        add_row(-32768, 0, 32767, 0, 0, 32767, 32766, 0, 0, 0);
        add_row(-32768, 0, 32767, 0, 0, -32768, 65535, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, 32767, 32767, 65535, 0, 0, 0);
        add_row(0, -32768, 0, 32767, -32768, 100, 32768, 0, 0, 0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stimulus_rows[i]) begin
            send_query(stimulus_rows[i]);
        end
        s_valid <= 1'b0;
        drain_results();

        for (int i = 0; i < RANDOM_QUERIES; i++) begin
            quiet <= (i >= 250) && (i < 400);
            pick = $urandom_range(99);
            if (pick < 40) begin
                mode = MODE_WIDE;
            end else if (pick < 70) begin
                mode = MODE_CLUSTER;
            end else begin
                mode = MODE_AXIS;
            end
            send_query(random_query(mode));
        end
        s_valid <= 1'b0;
        quiet   <= 1'b0;
        drain_results();
        repeat (20) @(posedge aclk);

        $display("ran %0d segment queries (%0d directed), %0d results checked",
                 queries_in, stimulus_rows.size(), verdicts_out);
        $display("results with hit: %0d, with projection inside span: %0d",
                 hits_seen, spans_seen);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors,
                     pending_verdicts.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/sch_pkg.sv
design/sch_mul.sv
design/sch_geom.sv
design/sch_decide.sv
design/segment_circle_hit_test.sv
design/sch_checker.sv
dv/testbench.sv
